FILE: sv/hts_pkg.sv
// Package for the HTML tag stripper: result type, tag match codes and
// character constants. No dependencies.
package hts_pkg;

  localparam logic [7:0] ChOpen  = 8'h3C;  // '<'
  localparam logic [7:0] ChClose = 8'h3E;  // '>'
  localparam logic [7:0] ChB     = 8'h42;  // 'B'
  localparam logic [7:0] ChR     = 8'h52;  // 'R'
  localparam logic [7:0] ChP     = 8'h50;  // 'P'
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] CaseBit = 8'h20;

  // Result queue geometry.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    MATCH_NONE = 3'd0,
    MATCH_LT   = 3'd1,
    MATCH_B    = 3'd2,
    MATCH_BR   = 3'd3,
    MATCH_P    = 3'd4
  } match_e;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_done;
    logic       any_output;
    logic       last_of_run;
  } result_t;

  // What the parser hands the result queue for one transaction.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ChLowA && c <= ChLowZ) begin
      r = c - CaseBit;
    end
    return r;
  endfunction

endpackage

FILE: sv/hts_parser.sv
// Tag parser for the HTML tag stripper: holds the tag state and turns one
// accepted transaction into zero, one or two results. Uses hts_pkg.
module hts_parser
  import hts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_text_i,
  output push_t      push_o
);

  logic   inside_tag_q, inside_tag_d;
  match_e match_q, match_d;
  logic   wrote_any_q, wrote_any_d;
  logic [7:0] upc;

  assign upc = upcase(in_char_i);

  always_comb begin
    inside_tag_d = inside_tag_q;
    match_d      = match_q;
    wrote_any_d  = wrote_any_q;
    push_o       = '0;
    if (end_of_text_i) begin
      // Close the string: report and clear.
      push_o.count              = 2'd1;
      push_o.first.is_done      = 1'b1;
      push_o.first.any_output   = wrote_any_q;
      push_o.first.last_of_run  = 1'b1;
      inside_tag_d = 1'b0;
      match_d      = MATCH_NONE;
      wrote_any_d  = 1'b0;
    end else if (in_char_i == ChOpen) begin
      // A nested '<' restarts the tag.
      inside_tag_d = 1'b1;
      match_d      = MATCH_LT;
    end else if (in_char_i == ChClose) begin
      inside_tag_d = 1'b0;
      match_d      = MATCH_NONE;
      if (inside_tag_q && (match_q == MATCH_BR || match_q == MATCH_P)) begin
        push_o.count              = 2'd2;
        push_o.first.out_char     = ChCr;
        push_o.second.out_char    = ChLf;
        push_o.second.last_of_run = 1'b1;
        wrote_any_d               = 1'b1;
      end
    end else if (inside_tag_q) begin
      unique case (match_q)
        MATCH_LT: begin
          if (upc == ChB) begin
            match_d = MATCH_B;
          end else if (upc == ChP) begin
            match_d = MATCH_P;
          end else begin
            match_d = MATCH_NONE;
          end
        end
        MATCH_B: begin
          match_d = (upc == ChR) ? MATCH_BR : MATCH_NONE;
        end
        default: begin
          match_d = MATCH_NONE;
        end
      endcase
    end else begin
      push_o.count             = 2'd1;
      push_o.first.out_char    = in_char_i;
      push_o.first.last_of_run = 1'b1;
      wrote_any_d              = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_tag_q <= 1'b0;
      match_q      <= MATCH_NONE;
      wrote_any_q  <= 1'b0;
    end else if (accept_i) begin
      inside_tag_q <= inside_tag_d;
      match_q      <= match_d;
      wrote_any_q  <= wrote_any_d;
    end
  end

endmodule

FILE: sv/hts_result_q.sv
// Result queue for the HTML tag stripper: a small register queue that takes
// up to two results per cycle and hands out one. Uses hts_pkg.
module hts_result_q
  import hts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_en_i,
  input  push_t   push_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  result_t          entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [1:0]       n_push;
  logic             pop;
  logic [QPtrW-1:0] wr_next;

  assign n_push      = push_en_i ? push_i.count : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = entry_q[rd_ptr_q];
  // Room for a full pair, counted without the pop of this cycle.
  assign space_o     = (cnt_q <= QCntW'(QDepth - 2));
  assign wr_next     = wr_ptr_q + QPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(n_push);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop);
    cnt_d    = cnt_q + QCntW'(n_push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.first;
    end
    if (n_push == 2'd2) begin
      entry_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: sv/html_tag_stripper.sv
// Top level of the HTML tag stripper: parser plus result queue.
// Depends on hts_pkg, hts_parser and hts_result_q.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one text byte per
//   transaction, or an end-of-text marker. Output channel (out_valid_o /
//   out_ready_i) carries one result byte per transaction with its flags.
//   Bytes from '<' through the next '>' are dropped; a <BR> or <P> tag
//   (either case) becomes CR then LF, both produced by the closing '>'.
//   An end transaction yields one result with is_done_o set and
//   any_output_o telling whether any byte went out since the last end.
// Timing: a result is written into the result queue when its input
//   transaction is accepted and is shown on the output from the queue head.
// Throughput: one input transaction per cycle while in_ready_o is high;
//   each result takes one output transaction, so a CR LF pair takes two and
//   the four-entry result queue absorbs the extra one. in_ready_o drops
//   only when the queue cannot take a full pair.
// Reset: clears the tag state, the written flag and the result queue.
// Receiver stall: results wait in the queue, unchanged on the ports; input
//   keeps flowing until the queue holds more than two results.
module html_tag_stripper
  import hts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       is_done_o,
  output logic       any_output_o,
  output logic       last_of_run_o
);

  logic    accept;
  push_t   push;
  result_t head;

  // Accept a transaction whenever the queue has room for a pair.
  assign accept = in_valid_i && in_ready_o;

  hts_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_char_i    (in_char_i),
    .end_of_text_i(end_of_text_i),
    .push_o       (push)
  );

  hts_result_q u_result_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_en_i  (accept),
    .push_i     (push),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (head)
  );

  // Drive the result fields from the queue head.
  assign out_char_o    = head.out_char;
  assign is_done_o     = head.is_done;
  assign any_output_o  = head.any_output;
  assign last_of_run_o = head.last_of_run;

endmodule

FILE: sv/hts_checker.sv
// Port-level checks for the HTML tag stripper, bound to the top level.
// Uses hts_pkg for character constants.
module hts_checker
  import hts_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       is_done_o,
  input logic       any_output_o,
  input logic       last_of_run_o
);

  // An end result carries no character and closes its run.
  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_done_o |-> out_char_o == 8'h00 && last_of_run_o)
    else $error("end result malformed");

  // any_output only appears on end results.
  a_any_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && any_output_o |-> is_done_o)
    else $error("any_output on byte result");

  // A result that is not last of its run is the CR of a pair, and the LF
  // is queued right behind it.
  a_cr_then_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o
      |-> out_char_o == ChCr ##1 out_valid_o && out_char_o == ChLf
          && last_of_run_o && !is_done_o)
    else $error("CR not followed by LF");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(is_done_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

endmodule

bind html_tag_stripper hts_checker u_hts_checker (.*);

FILE: verif/html_tag_stripper_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for html_tag_stripper: a strip scoreboard class
// predicts every result; a task and a receiver block drive the channels.
// Depends on hts_pkg and the html_tag_stripper RTL.

class strip_scoreboard;
  bit               in_tag;
  hts_pkg::match_e  tag_step;
  bit               wrote_any;
  hts_pkg::result_t expected_q[$];
  int unsigned      errors;

  function new();
    in_tag    = 1'b0;
    tag_step  = hts_pkg::MATCH_NONE;
    wrote_any = 1'b0;
    errors    = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Advance the tag state by one accepted input transaction and queue
  // the results that it causes.
  function void note_input(logic [7:0] ch, logic eot);
    hts_pkg::result_t r;
    logic [7:0]       up;
    logic             brk;
    r.out_char    = 8'h00;
    r.is_done     = 1'b0;
    r.any_output  = 1'b0;
    r.last_of_run = 1'b1;
    if (eot) begin
      r.is_done    = 1'b1;
      r.any_output = wrote_any;
      expected_q.push_back(r);
      in_tag    = 1'b0;
      tag_step  = hts_pkg::MATCH_NONE;
      wrote_any = 1'b0;
    end else if (ch == hts_pkg::ChOpen) begin
      // A '<' always restarts the tag, even inside one.
      in_tag   = 1'b1;
      tag_step = hts_pkg::MATCH_LT;
    end else if (ch == hts_pkg::ChClose) begin
      brk = in_tag && (tag_step == hts_pkg::MATCH_BR || tag_step == hts_pkg::MATCH_P);
      in_tag   = 1'b0;
      tag_step = hts_pkg::MATCH_NONE;
      if (brk) begin
        r.out_char    = hts_pkg::ChCr;
        r.last_of_run = 1'b0;
        expected_q.push_back(r);
        r.out_char    = hts_pkg::ChLf;
        r.last_of_run = 1'b1;
        expected_q.push_back(r);
        wrote_any = 1'b1;
      end
    end else if (in_tag) begin
      up = (ch >= hts_pkg::ChLowA && ch <= hts_pkg::ChLowZ) ? (ch & ~hts_pkg::CaseBit) : ch;
      case (tag_step)
        hts_pkg::MATCH_LT: begin
          if (up == hts_pkg::ChB) tag_step = hts_pkg::MATCH_B;
          else if (up == hts_pkg::ChP) tag_step = hts_pkg::MATCH_P;
          else tag_step = hts_pkg::MATCH_NONE;
        end
        hts_pkg::MATCH_B: begin
          tag_step = (up == hts_pkg::ChR) ? hts_pkg::MATCH_BR : hts_pkg::MATCH_NONE;
        end
        default: tag_step = hts_pkg::MATCH_NONE;
      endcase
    end else begin
      r.out_char = ch;
      expected_q.push_back(r);
      wrote_any = 1'b1;
    end
  endfunction

  task check_result(hts_pkg::result_t got);
    hts_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result char %02h done %0b", got.out_char, got.is_done));
      return;
    end
    want = expected_q.pop_front();
    if (got.out_char !== want.out_char) begin
      report($sformatf("out_char got %02h want %02h", got.out_char, want.out_char));
    end
    if (got.is_done !== want.is_done) begin
      report($sformatf("is_done got %0b want %0b", got.is_done, want.is_done));
    end
    if (got.any_output !== want.any_output) begin
      report($sformatf("any_output got %0b want %0b", got.any_output, want.any_output));
    end
    if (got.last_of_run !== want.last_of_run) begin
      report($sformatf("last_of_run got %0b want %0b", got.last_of_run, want.last_of_run));
    end
  endtask
endclass

module html_tag_stripper_tb
  import hts_pkg::*;
();

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomItems  = 1200;
  localparam int unsigned MaxIdle      = 16;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned PressureLen  = 60;
  localparam int unsigned SettleCycles = 8;

  // One input transaction: a text byte or an end marker.
  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] in_char_i     = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic       is_done_o;
  logic       any_output_o;
  logic       last_of_run_o;

  strip_scoreboard sb;
  text_item_t      item_q[$];
  bit              tx_idle_on     = 1'b1;
  bit              rx_idle_on     = 1'b1;
  bit              churn_on       = 1'b1;
  int unsigned     rx_hold_cycles = 0;
  int unsigned     cycle_count    = 0;

  html_tag_stripper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_char_i     (in_char_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_o    (out_char_o),
    .is_done_o     (is_done_o),
    .any_output_o  (any_output_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: end the run if the block hangs or results never arrive.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("html_tag_stripper regression: fail");
      $finish;
    end
  end

  // Output monitor: every accepted result transaction goes to the
  // scoreboard. Sampled in the active region, so it sees pre-edge values.
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.out_char    = out_char_o;
      got.is_done     = is_done_o;
      got.any_output  = any_output_o;
      got.last_of_run = last_of_run_o;
      sb.check_result(got);
    end
  end

  // Receiver: draw a stall per result, or honor a long hold requested by
  // the main sequence. The hold is counted here, not by the sender.
  initial begin : receiver
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, MaxIdle) : 0;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic void push_byte(logic [7:0] ch);
    text_item_t it;
    it.ch  = ch;
    it.eot = 1'b0;
    item_q.push_back(it);
  endfunction

  // The character rides along on an end marker and must be ignored.
  function automatic void push_end(logic [7:0] ch);
    text_item_t it;
    it.ch  = ch;
    it.eot = 1'b1;
    item_q.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endfunction

  // Push a complete tag, flipping the case of each letter at random.
  function automatic void push_tag(string body);
    logic [7:0] ch;
    push_byte(ChOpen);
    for (int i = 0; i < body.len(); i++) begin
      ch = body[i];
      if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) begin
        ch = ch | CaseBit;
      end
      push_byte(ch);
    end
    push_byte(ChClose);
  endfunction

  // Push a break tag, either <BR> or <P>.
  function automatic void push_break_tag();
    if ($urandom_range(0, 1) == 1) begin
      push_tag("BR");
    end else begin
      push_tag("P");
    end
  endfunction

  // Any byte except the two tag delimiters.
  function automatic logic [7:0] plain_byte();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom_range(0, 255));
    end while (ch == ChOpen || ch == ChClose);
    return ch;
  endfunction

  // Mostly well-formed text with break tags, plus other tags, near misses,
  // nested and stray delimiters, unclosed tags and raw noise.
  function automatic void build_random_items(int unsigned target);
    string near_miss[9] = '{"B", "BRR", "PR", "R", "B R", "BP", "PB", "", "RB"};
    while (item_q.size() < target) begin
      case ($urandom_range(0, 11))
        0, 1, 2: repeat ($urandom_range(1, 8)) push_byte(plain_byte());
        3, 4:    push_break_tag();
        5: begin
          push_byte(ChOpen);
          repeat ($urandom_range(0, 5)) push_byte(plain_byte());
          push_byte(ChClose);
        end
        6: push_tag(near_miss[$urandom_range(0, 8)]);
        7: begin
          // Nested open: the inner tag decides the outcome.
          push_byte(ChOpen);
          repeat ($urandom_range(0, 3)) push_byte(plain_byte());
          push_break_tag();
        end
        8: push_byte(ChClose);
        9: push_end(8'($urandom_range(0, 255)));
        10: repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        default: begin
          // Tag left open when the text ends.
          push_byte(ChOpen);
          if ($urandom_range(0, 1)) push_text("b");
          if ($urandom_range(0, 1)) push_text("R");
          push_end(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  // Drive every queued item. Hold valid and payload until the handshake;
  // keep valid high across back-to-back transactions.
  task automatic drive_items();
    text_item_t  it;
    int unsigned gap;
    while (item_q.size() != 0) begin
      it = item_q.pop_front();
      if (churn_on && $urandom_range(0, 49) == 0) tx_idle_on = !tx_idle_on;
      if (churn_on && $urandom_range(0, 49) == 0) rx_idle_on = !rx_idle_on;
      gap = tx_idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      in_char_i     <= it.ch;
      end_of_text_i <= it.eot;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sb.note_input(it.ch, it.eot);
    end
  endtask

  // Drop valid and pause until every predicted result has come back.
  // The loop checks after an edge, so valid never drops and rises at once.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin : main_sequence
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, both break tags, stray and nested
    // delimiters, end with and without output, unclosed tag at end.
    push_text("a");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("<Br>");
    push_text("<p>");
    push_text(">");
    push_text("<x<P>");
    push_end(8'h00);
    push_end(8'hFF);
    push_text("<q>");
    push_text("<bR");
    push_end(ChClose);
    drive_items();
    drain_results();

    // Pressure: hold off the receiver while the sender streams text and
    // breaks with no gaps, so the result queue fills and stalls input.
    churn_on       = 1'b0;
    tx_idle_on     = 1'b0;
    rx_hold_cycles = LongHold;
    while (item_q.size() < PressureLen) begin
      push_byte(plain_byte());
      if ($urandom_range(0, 3) == 0) push_tag("BR");
    end
    push_end(8'h00);
    drive_items();
    drain_results();

    // Random: idle modes churn on both sides as the stream goes by.
    churn_on   = 1'b1;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    build_random_items(RandomItems);
    drive_items();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("html_tag_stripper regression: pass");
    end else begin
      $display("html_tag_stripper regression: fail");
    end
    $finish;
  end

endmodule
